// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- src/s2a_pkg.sv -----
// types, constants and translation tables for the scancode to ascii block
`default_nettype none

package s2a_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int PTR_W        = $clog2(BUFFER_DEPTH);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QIDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CHAR_W       = 7;
   localparam int CODE_W       = 8;
   localparam int TABLE_SIZE   = 64;

   localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;

   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_READ,
      CMD_APPEND
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] ch;
      logic              shift;
   } cmd_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              char_valid;
      logic              has_char;
      logic              dropped;
      logic              shift_active;
   } rsp_fields_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

   localparam logic [CHAR_W-1:0] PLAIN_MAP [TABLE_SIZE] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   localparam logic [CHAR_W-1:0] SHIFT_MAP [TABLE_SIZE] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   function automatic logic [CHAR_W-1:0] scan_lookup(input logic [5:0] idx,
                                                     input logic shifted);
      return shifted ? SHIFT_MAP[idx] : PLAIN_MAP[idx];
   endfunction

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ----- src/s2a_if.sv -----
// request and response channel interfaces
`default_nettype none

interface s2a_req_if;
   import s2a_pkg::*;
   logic              valid;
   logic              ready;
   logic              operation;
   logic [CODE_W-1:0] scan_code;

   modport source (output valid, output operation, output scan_code, input ready);
   modport sink   (input valid, input operation, input scan_code, output ready);
endinterface

interface s2a_rsp_if;
   import s2a_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              char_valid;
   logic              has_char;
   logic              dropped;
   logic              shift_active;

   modport source (output valid, output out_char, output char_valid, output has_char,
                   output dropped, output shift_active, input ready);
   modport sink   (input valid, input out_char, input char_valid, input has_char,
                   input dropped, input shift_active, output ready);
endinterface

`default_nettype wire

// ----- src/s2a_front.sv -----
// front end: takes items, tracks shift and translates scancodes
`default_nettype none
`include "assert_macros.svh"

module s2a_front (
   input  wire logic             clock,
   input  wire logic             reset,
   s2a_req_if.sink               req_bus,
   input  wire logic             q_ready,
   output logic                  q_valid,
   output s2a_pkg::cmd_type      q_cmd
);
   import s2a_pkg::*;

   logic              shift_ff;
   logic              shift_in;
   logic              fire;
   logic [CHAR_W-1:0] ch;

   assign req_bus.ready = q_ready;
   assign q_valid       = req_bus.valid;
   assign fire          = req_bus.valid && q_ready;

   always_comb begin
      shift_in   = shift_ff;
      ch         = scan_lookup(req_bus.scan_code[5:0], shift_ff);
      q_cmd.kind = CMD_NONE;
      q_cmd.ch   = ch;
      if (req_bus.operation == OP_READ) begin
         q_cmd.kind = CMD_READ;
      end else if (req_bus.scan_code == SC_LSHIFT_MAKE ||
                   req_bus.scan_code == SC_RSHIFT_MAKE) begin
         shift_in = 1'b1;
      end else if (req_bus.scan_code == SC_LSHIFT_BREAK ||
                   req_bus.scan_code == SC_RSHIFT_BREAK) begin
         shift_in = 1'b0;
      end else if (req_bus.scan_code[7:6] == 2'b00 && ch != '0) begin
         q_cmd.kind = CMD_APPEND;
      end
      q_cmd.shift = shift_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
      end else if (fire) begin
         shift_ff <= shift_in;
      end
   end

   `ASSERT_PROP(a_shift_make_sets, (fire && req_bus.operation == OP_SCAN && (req_bus.scan_code == SC_LSHIFT_MAKE || req_bus.scan_code == SC_RSHIFT_MAKE)) |=> shift_ff)

endmodule

`default_nettype wire

// ----- src/s2a_queue.sv -----
// short command queue between front and back end
`default_nettype none
`include "assert_macros.svh"

module s2a_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire s2a_pkg::cmd_type in_cmd,
   output logic                  out_valid,
   input  wire logic             out_pop,
   output s2a_pkg::cmd_type      out_cmd
);
   import s2a_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0] head_ff, head_in;
   logic [QIDX_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;

   function automatic logic [QIDX_W-1:0] idx_next(input logic [QIDX_W-1:0] i);
      return (i == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[head_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      head_in  = pop  ? idx_next(head_ff) : head_ff;
      tail_in  = push ? idx_next(tail_ff) : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= in_cmd;
      end
   end

   `ASSERT_NEVER(a_pop_when_empty, out_pop && count_ff == '0)
   `ASSERT_PROP(a_count_bound, count_ff <= QCNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ----- src/s2a_back.sv -----
// back end: character ring buffer and response register
`default_nettype none
`include "assert_macros.svh"

module s2a_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire s2a_pkg::cmd_type q_cmd,
   output logic                  q_pop,
   s2a_rsp_if.source             rsp_bus
);
   import s2a_pkg::*;

   logic [CHAR_W-1:0] store_mem [BUFFER_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   back_state_type    state_ff, state_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic              pend_shift_ff, pend_shift_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_fields_type    rsp_data_ff, rsp_data_in;

   logic              slot_free;
   logic              not_empty;
   logic              room;
   logic              mem_we;
   logic              load;
   logic              start_read;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign not_empty = (rd_ptr_ff != wr_ptr_ff);
   assign room      = (ring_next(wr_ptr_ff) != rd_ptr_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (start_read) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      load          = 1'b0;
      start_read    = 1'b0;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      pend_shift_in = pend_shift_ff;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop                    = 1'b1;
               rsp_data_in.out_char     = '0;
               rsp_data_in.char_valid   = 1'b0;
               rsp_data_in.has_char     = not_empty;
               rsp_data_in.dropped      = 1'b0;
               rsp_data_in.shift_active = q_cmd.shift;
               load                     = 1'b1;
               case (q_cmd.kind)
                  CMD_READ: begin
                     if (not_empty) begin
                        start_read    = 1'b1;
                        load          = 1'b0;
                        rd_ptr_in     = ring_next(rd_ptr_ff);
                        pend_shift_in = q_cmd.shift;
                     end
                  end
                  CMD_APPEND: begin
                     if (room) begin
                        mem_we               = 1'b1;
                        wr_ptr_in            = ring_next(wr_ptr_ff);
                        rsp_data_in.has_char = 1'b1;
                     end else begin
                        rsp_data_in.dropped = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_READ: begin
            load                     = 1'b1;
            rsp_data_in.out_char     = rd_data_ff;
            rsp_data_in.char_valid   = 1'b1;
            rsp_data_in.has_char     = not_empty;
            rsp_data_in.dropped      = 1'b0;
            rsp_data_in.shift_active = pend_shift_ff;
         end
         default: ;
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_shift_ff <= pend_shift_in;
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_ptr_ff] <= q_cmd.ch;
      end
      rd_data_ff <= store_mem[rd_ptr_ff];
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_char     = rsp_data_ff.out_char;
   assign rsp_bus.char_valid   = rsp_data_ff.char_valid;
   assign rsp_bus.has_char     = rsp_data_ff.has_char;
   assign rsp_bus.dropped      = rsp_data_ff.dropped;
   assign rsp_bus.shift_active = rsp_data_ff.shift_active;

   `ASSERT_PROP(a_read_slot_free, state_ff == BK_READ |-> !rsp_valid_ff)
   `ASSERT_NEVER(a_write_when_full, mem_we && ring_next(wr_ptr_ff) == rd_ptr_ff)

endmodule

`default_nettype wire

// ----- src/scancode_to_ascii_fifo_core.sv -----
// top level: set-1 scancode to ascii translator with character ring buffer
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    operation, scan_code
//   rsp_bus   out   valid/ready    out_char, char_valid, has_char, dropped, shift_active
//
// the front end takes one item per cycle while the two-entry command queue has room
// the back end retires a scancode item straight from its idle state; a read of a stored
// character also passes the read state, for the registered read of the buffer memory
// a finished item waits in the response register; the back end stalls only on it
// reset clears the shift flag, the buffer pointers and the queue; buffer contents
// are not cleared and need no pass after reset
`default_nettype none

module scancode_to_ascii_fifo_core (
   input  wire logic clock,
   input  wire logic reset,
   s2a_req_if.sink   req_bus,
   s2a_rsp_if.source rsp_bus
);
   import s2a_pkg::*;

   logic    fq_valid;
   logic    fq_ready;
   cmd_type fq_cmd;
   logic    qb_valid;
   logic    qb_pop;
   cmd_type qb_cmd;

   s2a_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_ready (fq_ready),
      .q_valid (fq_valid),
      .q_cmd   (fq_cmd)
   );

   s2a_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_cmd    (fq_cmd),
      .out_valid (qb_valid),
      .out_pop   (qb_pop),
      .out_cmd   (qb_cmd)
   );

   s2a_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (qb_valid),
      .q_cmd   (qb_cmd),
      .q_pop   (qb_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire
